// ----- hdl/ssm_pkg.sv -----
// Shared constants, types and byte classifiers for the sentence segment marker.
package ssm_pkg;

  localparam int unsigned LOOKAHEAD_DEF = 12;
  // Window bytes, head included, that the abbreviation tags need in view.
  localparam int unsigned TAG_SPAN      = 12;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_Z      = 8'h5A;

  localparam logic [7:0] U8_C2 = 8'hC2;
  localparam logic [7:0] U8_BB = 8'hBB;
  localparam logic [7:0] U8_E2 = 8'hE2;
  localparam logic [7:0] U8_E3 = 8'hE3;
  localparam logic [7:0] U8_EF = 8'hEF;
  localparam logic [7:0] U8_80 = 8'h80;
  localparam logic [7:0] U8_BC = 8'hBC;
  localparam logic [7:0] U8_9D = 8'h9D;
  localparam logic [7:0] U8_99 = 8'h99;
  localparam logic [7:0] U8_A6 = 8'hA6;
  localparam logic [7:0] U8_82 = 8'h82;
  localparam logic [7:0] U8_81 = 8'h81;
  localparam logic [7:0] U8_9F = 8'h9F;
  localparam logic [7:0] U8_89 = 8'h89;
  localparam logic [7:0] U8_91 = 8'h91;
  localparam logic [7:0] U8_8B = 8'h8B;
  localparam logic [7:0] U8_8D = 8'h8D;
  localparam logic [7:0] U8_8F = 8'h8F;

  typedef enum logic [1:0] {
    MODE_SCAN   = 2'd0,
    MODE_CLOSER = 2'd1,
    MODE_SPACE  = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic emit_req;    // head byte may leave the window
    logic final_head;  // head is the last byte of the text
  } win_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Length of a closing quote or bracket starting at b0, zero if none.
  function automatic logic [1:0] closer_bytes(input logic [2:0] ok,
                                              input logic [7:0] b0,
                                              input logic [7:0] b1,
                                              input logic [7:0] b2);
    logic tri3;
    logic [1:0] len;
    tri3 = (&ok) &&
           (((b0 == U8_E2) && (b1 == U8_80) && ((b2 == U8_9D) || (b2 == U8_99))) ||
            ((b0 == U8_EF) && (b1 == U8_BC) && (b2 == U8_89)) ||
            ((b0 == U8_E3) && (b1 == U8_80) &&
             ((b2 == U8_91) || (b2 == U8_8B) || (b2 == U8_89) ||
              (b2 == U8_8D) || (b2 == U8_8F))));
    if (ok[0] && ((b0 == CH_DQUOTE) || (b0 == CH_RPAREN) || (b0 == CH_APOS))) begin
      len = 2'd1;
    end else if (ok[0] && ok[1] && (b0 == U8_C2) && (b1 == U8_BB)) begin
      len = 2'd2;
    end else if (tri3) begin
      len = 2'd3;
    end else begin
      len = 2'd0;
    end
    return len;
  endfunction

endpackage

// ----- hdl/ssm_if.sv -----
// Stream interfaces for text requests in and marked bytes out.
interface ssm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ssm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       segment_end;
  logic       last_byte;

  modport source (output valid, out_byte, segment_end, last_byte, input ready);
  modport sink   (input valid, out_byte, segment_end, last_byte, output ready);
endinterface

// ----- hdl/ssm_window.sv -----
// Lookahead window: byte shift register, fill count and end-of-text drain control.
module ssm_window
  import ssm_pkg::*;
#(
  parameter int unsigned LOOKAHEAD = LOOKAHEAD_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [7:0]                in_byte,
  input  logic                      in_eot,
  input  logic                      fire,
  output logic                      in_ready,
  output logic [LOOKAHEAD-1:0][7:0] win,
  output logic [LOOKAHEAD-1:0]      avail,
  output win_stat_t                 stat
);

  localparam int unsigned FW = $clog2(LOOKAHEAD + 1);

  logic [LOOKAHEAD-1:0][7:0] win_r, win_nxt, shifted;
  logic [FW-1:0]             fill_r, fill_nxt, pos;
  logic                      drain_r, drain_nxt;
  logic                      full, accept, done;

  always_comb begin
    full            = (fill_r == FW'(LOOKAHEAD));
    stat.emit_req   = drain_r ? (fill_r != '0) : full;
    stat.final_head = drain_r && (fill_r == FW'(1));
  end

  always_comb begin
    in_ready        = !drain_r && (!full || fire);
    accept          = in_valid && in_ready;
    done            = fire && stat.final_head;
    pos             = fill_r - {{(FW-1){1'b0}}, fire};

    for (int i = 0; i < LOOKAHEAD - 1; i++) begin
      shifted[i] = win_r[i+1];
    end
    shifted[LOOKAHEAD-1] = win_r[LOOKAHEAD-1];

    for (int i = 0; i < LOOKAHEAD; i++) begin
      win_nxt[i] = fire ? shifted[i] : win_r[i];
      if (accept && (pos == FW'(i))) begin
        win_nxt[i] = in_byte;
      end
      avail[i] = (FW'(i) < fill_r);
    end

    if (done) begin
      fill_nxt  = '0;
      drain_nxt = 1'b0;
    end else begin
      fill_nxt  = fill_r - {{(FW-1){1'b0}}, fire} + {{(FW-1){1'b0}}, accept};
      drain_nxt = drain_r || (accept && in_eot);
    end
  end

  assign win = win_r;

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      drain_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ----- hdl/ssm_scan.sv -----
// Boundary scanner: mark, closer and space tracking over the head of the window.
module ssm_scan
  import ssm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TAG_SPAN-1:0][7:0] win,
  input  logic [TAG_SPAN-1:0]      avail,
  input  win_stat_t                stat,
  input  logic                     fire,
  output logic                     seg_end
);

  scan_mode_t mode_r, mode_nxt, td_mode;
  logic [1:0] skip_r, skip_nxt;
  logic [7:0] prev_r;
  logic       have_prev_r;

  logic [1:0] c0_len, c1_len, mark_len;
  logic       td_seg, prot, dot_end, tag_hit, rdq_next, scan;
  logic [7:0] b0, b1, b2, b3, b4;

  always_comb begin
    b0 = win[0];
    b1 = win[1];
    b2 = win[2];
    b3 = win[3];
    b4 = win[4];

    c0_len = closer_bytes(avail[2:0], b0, b1, b2);
    c1_len = closer_bytes(avail[3:1], b1, b2, b3);

    // Decide whether the segment ends after the head byte.
    if (!avail[1]) begin
      td_seg  = 1'b1;
      td_mode = MODE_SCAN;
    end else if (c1_len != 2'd0) begin
      td_seg  = 1'b0;
      td_mode = MODE_CLOSER;
    end else if (b1 == CH_SPACE) begin
      td_seg  = 1'b0;
      td_mode = MODE_SPACE;
    end else begin
      td_seg  = 1'b1;
      td_mode = MODE_SCAN;
    end

    tag_hit = avail[TAG_SPAN-1] &&
              (((b1 == CH_A) && (b2 == CH_B) && (b3 == CH_B) && (b4 == CH_R)) ||
               ((b1 == CH_D) && (b2 == CH_E) && (b3 == CH_C)) ||
               ((b1 == CH_U) && (b2 == CH_R) && (b3 == CH_L)));
    prot = tag_hit ||
           (have_prev_r && avail[1] &&
            ((is_digit(prev_r) && is_digit(b1)) ||
             (is_upper(prev_r) && is_space(b1))));
    rdq_next = avail[1] && avail[2] && avail[3] &&
               (b1 == U8_E2) && (b2 == U8_80) && (b3 == U8_9D);
    dot_end = !prot &&
              (!avail[1] || (b1 == CH_SPACE) || (b1 == CH_DQUOTE) ||
               (b1 == CH_RPAREN) || (avail[4] && rdq_next));

    if (avail[0] && (b0 == CH_DOT)) begin
      mark_len = dot_end ? 2'd1 : 2'd0;
    end else if (avail[0] && ((b0 == CH_BANG) || (b0 == CH_QUEST))) begin
      mark_len = 2'd1;
    end else if (avail[0] && avail[1] && avail[2] &&
                 (((b0 == U8_E2) && (b1 == U8_80) && (b2 == U8_A6)) ||
                  ((b0 == U8_E3) && (b1 == U8_80) && (b2 == U8_82)) ||
                  ((b0 == U8_EF) && (b1 == U8_BC) &&
                   ((b2 == U8_81) || (b2 == U8_9F))))) begin
      mark_len = 2'd3;
    end else begin
      mark_len = 2'd0;
    end

    seg_end  = 1'b0;
    mode_nxt = mode_r;
    skip_nxt = skip_r;
    scan     = 1'b0;

    if (skip_r != 2'd0) begin
      // Pass over the tail of a multi-byte mark or closer.
      skip_nxt = skip_r - 2'd1;
      if (skip_r == 2'd1) begin
        seg_end  = td_seg;
        mode_nxt = td_mode;
      end
    end else begin
      unique case (mode_r)
        MODE_SPACE: begin
          seg_end  = 1'b1;
          mode_nxt = MODE_SCAN;
        end
        MODE_CLOSER: begin
          if (c0_len > 2'd1) begin
            skip_nxt = c0_len - 2'd1;
          end else if (c0_len == 2'd1) begin
            seg_end  = td_seg;
            mode_nxt = td_mode;
          end else begin
            mode_nxt = MODE_SCAN;
            scan     = 1'b1;
          end
        end
        default: begin
          scan = 1'b1;
        end
      endcase
    end

    if (scan) begin
      if (mark_len > 2'd1) begin
        skip_nxt = mark_len - 2'd1;
        mode_nxt = MODE_SCAN;
      end else if (mark_len == 2'd1) begin
        seg_end  = td_seg;
        mode_nxt = td_mode;
      end
    end

    if (stat.final_head) begin
      seg_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SCAN;
      skip_r      <= 2'd0;
      prev_r      <= 8'h00;
      have_prev_r <= 1'b0;
    end else if (fire) begin
      if (stat.final_head) begin
        // Text over: start the next one from scratch.
        mode_r      <= MODE_SCAN;
        skip_r      <= 2'd0;
        prev_r      <= 8'h00;
        have_prev_r <= 1'b0;
      end else begin
        mode_r      <= mode_nxt;
        skip_r      <= skip_nxt;
        prev_r      <= b0;
        have_prev_r <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/sentence_segment_marker_core.sv -----
// Sentence segment marker top level: window, scanner and output register.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------------
//   in_ch    | in  | valid / ready    | text_byte[7:0], end_of_text
//   out_ch   | out | valid / ready    | out_byte[7:0], segment_end, last_byte
//
// One byte per cycle in steady flow while the output is ready; a byte leaves the
// window as its head once the window holds LOOKAHEAD bytes.
// On end_of_text the window drains one byte per cycle while the output is ready;
// no request is taken until the drain ends.
// Synchronous active-low reset empties the window and clears the scan state.
// A stalled output holds its register; the window keeps filling until full.
module sentence_segment_marker_core
  import ssm_pkg::*;
#(
  parameter int unsigned LOOKAHEAD = LOOKAHEAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ssm_in_if.sink     in_ch,
  ssm_out_if.source  out_ch
);

  logic [LOOKAHEAD-1:0][7:0] win;
  logic [LOOKAHEAD-1:0]      avail;
  win_stat_t                 stat;
  logic                      fire, win_ready, seg_end;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       seg_r, last_r;

  ssm_window #(
    .LOOKAHEAD (LOOKAHEAD)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.text_byte),
    .in_eot   (in_ch.end_of_text),
    .fire     (fire),
    .in_ready (win_ready),
    .win      (win),
    .avail    (avail),
    .stat     (stat)
  );

  ssm_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .win     (win[TAG_SPAN-1:0]),
    .avail   (avail[TAG_SPAN-1:0]),
    .stat    (stat),
    .fire    (fire),
    .seg_end (seg_end)
  );

  // Advance the head when it may leave the window and the output register is free or being emptied.
  assign fire        = stat.emit_req && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = win_ready;

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= win[0];
      seg_r      <= seg_end;
      last_r     <= stat.final_head;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.segment_end = seg_r;
  assign out_ch.last_byte   = last_r;

  // The final byte of a text always closes a segment.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_byte |-> out_ch.segment_end)
    else $error("last byte without segment end");

  // Taking the final byte of a text blocks further requests until the drain.
  a_eot_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.end_of_text |=> !in_ch.ready)
    else $error("request taken during drain");

  // Emitting the final byte leaves the window empty and ready.
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stat.final_head |=> !stat.emit_req && in_ch.ready)
    else $error("window not empty after last byte");

  // A head can only leave the window while draining or with it full.
  a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !stat.final_head |-> &avail || $past(in_ch.valid && in_ch.ready
      && in_ch.end_of_text) || !in_ch.ready)
    else $error("head emitted from a partial window");

endmodule

// ----- tb/sv/sentence_segment_marker_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sentence_segment_marker_core: scripted texts, then random ones.
module sentence_segment_marker_core_test;
  import ssm_pkg::*;

  localparam int unsigned DEPTH       = LOOKAHEAD_DEF;
  localparam int unsigned ITEMS       = 170;
  localparam int unsigned HOLD_AT     = 40;
  localparam int unsigned PAUSE_AT    = 90;
  localparam int unsigned CALM_AT     = 130;
  localparam int unsigned LONG_HOLD   = 90;
  localparam int unsigned STALL_LIMIT = 500;
  localparam logic [8:0]  NO_BYTE     = 9'h100;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       typed;   // expectation taken from the row, not the predictor
    logic       single;  // typed row causes exactly one marked byte
    logic       seg;
    logic       lst;
  } text_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       seg;
    logic       lst;
  } marked_t;

  localparam int unsigned N_SCRIPT = 26;

  logic clk = 1'b0;
  logic rst_n;

  ssm_in_if  in_ch ();
  ssm_out_if out_ch ();

  sentence_segment_marker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Directed texts: single-byte texts, then digits, initials, marks and closers.
  text_row_t script [N_SCRIPT] = '{
    '{8'h00,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
    '{8'hFF,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
    '{CH_DOT,    1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
    '{8'h33,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CH_DOT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h35,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_SPACE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_DOT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h53,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_DOT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_SPACE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h6F,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_QUEST,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_SPACE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_E,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{U8_E2,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{U8_80,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{U8_A6,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_RPAREN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h78,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_DOT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{U8_E2,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{U8_80,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{U8_9D,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  marked_t     marked_q [$];
  logic [7:0]  draft [$];
  text_row_t   row_now;
  logic        hold_ask;
  logic        calm;
  int unsigned mismatches = 0;
  bit          muted;

  // Predictor state
  logic [7:0]  win [DEPTH];
  int unsigned fill;
  logic [7:0]  prev_b;
  logic        have_prev;
  scan_mode_t  mode;
  logic [1:0]  skip;

  function automatic void clear_window();
    foreach (win[i]) win[i] = 8'h00;
    fill      = 0;
    prev_b    = 8'h00;
    have_prev = 1'b0;
    mode      = MODE_SCAN;
    skip      = 2'd0;
  endfunction

  function automatic logic [8:0] peek(input int unsigned k);
    return (k < fill) ? {1'b0, win[k]} : NO_BYTE;
  endfunction

  function automatic logic tri_at(input int unsigned k, input logic [7:0] a,
                                  input logic [7:0] b, input logic [7:0] c);
    return (peek(k) == a) && (peek(k + 1) == b) && (peek(k + 2) == c);
  endfunction

  function automatic int unsigned closer_span(input int unsigned k);
    logic [8:0] c;
    c = peek(k);
    if ((c == CH_DQUOTE) || (c == CH_RPAREN) || (c == CH_APOS)) return 1;
    if ((c == U8_C2) && (peek(k + 1) == U8_BB)) return 2;
    if (tri_at(k, U8_E2, U8_80, U8_9D) || tri_at(k, U8_E2, U8_80, U8_99) ||
        tri_at(k, U8_EF, U8_BC, U8_89) || tri_at(k, U8_E3, U8_80, U8_91) ||
        tri_at(k, U8_E3, U8_80, U8_8B) || tri_at(k, U8_E3, U8_80, U8_89) ||
        tri_at(k, U8_E3, U8_80, U8_8D) || tri_at(k, U8_E3, U8_80, U8_8F))
      return 3;
    return 0;
  endfunction

  function automatic logic dot_guarded();
    logic [8:0] n;
    if (TAG_SPAN - 1 < fill) begin
      if ((peek(1) == CH_A) && (peek(2) == CH_B) && (peek(3) == CH_B) && (peek(4) == CH_R))
        return 1'b1;
      if ((peek(1) == CH_D) && (peek(2) == CH_E) && (peek(3) == CH_C)) return 1'b1;
      if ((peek(1) == CH_U) && (peek(2) == CH_R) && (peek(3) == CH_L)) return 1'b1;
    end
    if (have_prev && (fill > 1)) begin
      n = peek(1);
      if ((prev_b >= 8'h30) && (prev_b <= 8'h39) && (n >= 9'h030) && (n <= 9'h039))
        return 1'b1;
      if ((prev_b >= 8'h41) && (prev_b <= 8'h5A) &&
          ((n == 9'h020) || ((n >= 9'h009) && (n <= 9'h00D))))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned mark_span();
    logic [8:0] c;
    logic [8:0] n;
    c = peek(0);
    if (c == CH_DOT) begin
      if (dot_guarded()) return 0;
      if (fill < 2) return 1;
      n = peek(1);
      if ((n == CH_SPACE) || (n == CH_DQUOTE) || (n == CH_RPAREN)) return 1;
      if ((fill > 4) && tri_at(1, U8_E2, U8_80, U8_9D)) return 1;
      return 0;
    end
    if ((c == CH_BANG) || (c == CH_QUEST)) return 1;
    if (tri_at(0, U8_E2, U8_80, U8_A6) || tri_at(0, U8_E3, U8_80, U8_82) ||
        tri_at(0, U8_EF, U8_BC, U8_81) || tri_at(0, U8_EF, U8_BC, U8_9F))
      return 3;
    return 0;
  endfunction

  // Head finishes a mark or closer: end here unless closers or a space follow.
  function automatic logic close_token();
    if (fill < 2) begin
      mode = MODE_SCAN;
      return 1'b1;
    end
    if (closer_span(1) != 0) begin
      mode = MODE_CLOSER;
      return 1'b0;
    end
    if (peek(1) == CH_SPACE) begin
      mode = MODE_SPACE;
      return 1'b0;
    end
    mode = MODE_SCAN;
    return 1'b1;
  endfunction

  function automatic void pass_head(input bit at_end);
    marked_t     r;
    bit          scan;
    int unsigned n;
    r.b   = win[0];
    r.seg = 1'b0;
    scan  = 1'b0;
    if (skip != 2'd0) begin
      skip = skip - 2'd1;
      if (skip == 2'd0) r.seg = close_token();
    end else if (mode == MODE_SPACE) begin
      r.seg = 1'b1;
      mode  = MODE_SCAN;
    end else if (mode == MODE_CLOSER) begin
      n = closer_span(0);
      if (n > 1) begin
        skip = 2'(n - 1);
      end else if (n == 1) begin
        r.seg = close_token();
      end else begin
        mode = MODE_SCAN;
        scan = 1'b1;
      end
    end else begin
      scan = 1'b1;
    end
    if (scan) begin
      n = mark_span();
      if (n > 1) begin
        skip = 2'(n - 1);
        mode = MODE_SCAN;
      end else if (n == 1) begin
        r.seg = close_token();
      end
    end
    r.lst = at_end && (fill == 1);
    if (r.lst) r.seg = 1'b1;
    if (!muted) marked_q.insert(marked_q.size(), r);
    prev_b    = r.b;
    have_prev = 1'b1;
    for (int i = 0; i < DEPTH - 1; i++) win[i] = win[i + 1];
    fill--;
  endfunction

  function automatic void take_text_byte(input logic [7:0] b, input logic eot);
    win[fill] = b;
    fill++;
    if (eot) begin
      while (fill > 0) pass_head(1'b1);
      clear_window();
    end else if (fill == DEPTH) begin
      pass_head(1'b0);
    end
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("[%0t] %s: got %02h, want %02h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    draft.insert(draft.size(), b);
  endfunction

  function automatic void push3(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c);
    add_byte(a);
    add_byte(b);
    add_byte(c);
  endfunction

  function automatic logic [7:0] any_space();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'(8'h09 + $urandom_range(0, 4));
  endfunction

  function automatic void push_closer();
    case ($urandom_range(0, 11))
      0:       push3(U8_E2, U8_80, U8_9D);
      1:       push3(U8_E2, U8_80, U8_99);
      2:       push3(U8_EF, U8_BC, U8_89);
      3:       push3(U8_E3, U8_80, U8_91);
      4:       push3(U8_E3, U8_80, U8_8B);
      5:       push3(U8_E3, U8_80, U8_89);
      6:       push3(U8_E3, U8_80, U8_8D);
      7:       push3(U8_E3, U8_80, U8_8F);
      8: begin
        add_byte(U8_C2);
        add_byte(U8_BB);
      end
      9:       add_byte(CH_DQUOTE);
      10:      add_byte(CH_RPAREN);
      default: add_byte(CH_APOS);
    endcase
  endfunction

  // Mostly prose with marks, closers and protected dots; some raw noise.
  function automatic void draft_text();
    int unsigned target;
    int unsigned pick;
    draft.delete();
    pick = $urandom_range(0, 19);
    if (pick < 5) target = $urandom_range(1, 8);
    else if (pick < 17) target = $urandom_range(9, 24);
    else target = $urandom_range(25, 40);
    while (draft.size() < target) begin
      case ($urandom_range(0, 23))
        0, 1, 2, 3: add_byte(8'(8'h61 + $urandom_range(0, 25)));
        4:          add_byte(8'(8'h41 + $urandom_range(0, 25)));
        5:          add_byte(8'(8'h30 + $urandom_range(0, 9)));
        6, 7:       add_byte(CH_SPACE);
        8, 9:       add_byte(CH_DOT);
        10:         add_byte(($urandom_range(0, 1) != 0) ? CH_BANG : CH_QUEST);
        11:         push3(U8_E2, U8_80, U8_A6);
        12: begin
          case ($urandom_range(0, 2))
            0:       push3(U8_E3, U8_80, U8_82);
            1:       push3(U8_EF, U8_BC, U8_81);
            default: push3(U8_EF, U8_BC, U8_9F);
          endcase
        end
        13, 14:     push_closer();
        15:         push3(U8_E2, U8_80, U8_9D);
        16: begin
          add_byte(CH_DOT);
          case ($urandom_range(0, 2))
            0: begin
              push3(CH_A, CH_B, CH_B);
              add_byte(CH_R);
            end
            1:       push3(CH_D, CH_E, CH_C);
            default: push3(CH_U, CH_R, CH_L);
          endcase
        end
        17:         push3(8'(8'h41 + $urandom_range(0, 25)), CH_DOT, any_space());
        18:         push3(8'(8'h30 + $urandom_range(0, 9)), CH_DOT,
                          8'(8'h30 + $urandom_range(0, 9)));
        19:         add_byte(any_space());
        20: begin
          // leave a multi-byte sequence cut short
          case ($urandom_range(0, 2))
            0: begin
              add_byte(U8_E2);
              add_byte(U8_80);
            end
            1:       add_byte(U8_C2);
            default: add_byte(U8_E3);
          endcase
        end
        21, 22:     add_byte(8'($urandom_range(0, 255)));
        default: begin
          add_byte(($urandom_range(0, 1) != 0) ? CH_DOT : CH_BANG);
          push_closer();
          add_byte(CH_SPACE);
        end
      endcase
    end
  endfunction

  task automatic offer_row(input text_row_t r);
    if (!calm && ($urandom_range(0, 5) == 0)) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= r.b;
    in_ch.end_of_text <= r.eot;
    row_now           <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial clear_window();

  // Predict on every accepted request.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      muted = row_now.typed;
      take_text_byte(in_ch.text_byte, in_ch.end_of_text);
      if (row_now.typed && row_now.single)
        marked_q.insert(marked_q.size(),
                        marked_t'{in_ch.text_byte, row_now.seg, row_now.lst});
    end
  end

  always @(posedge clk) begin
    marked_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (marked_q.size() == 0) begin
        report("unexpected byte", out_ch.out_byte, 8'h00);
      end else begin
        want = marked_q.pop_front();
        if (out_ch.out_byte != want.b)
          report("out_byte", out_ch.out_byte, want.b);
        if (out_ch.segment_end != want.seg)
          report("segment_end", 8'(out_ch.segment_end), 8'(want.seg));
        if (out_ch.last_byte != want.lst)
          report("last_byte", 8'(out_ch.last_byte), 8'(want.lst));
      end
    end
  end

  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_ask && !hold_done) begin
        // hold off long enough for the window to fill and stall the input
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && ($urandom_range(0, 4) == 0)) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    bit          paused;
    text_row_t   r;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    row_now           <= '0;
    hold_ask          <= 1'b0;
    calm              <= 1'b0;
    sent   = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      offer_row(script[i]);
      sent++;
    end

    while (sent < ITEMS) begin
      if (!paused && (sent >= PAUSE_AT)) begin
        // drain everything before the next text
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (marked_q.size() != 0) @(posedge clk);
      end
      draft_text();
      foreach (draft[i]) begin
        if (sent == HOLD_AT) hold_ask <= 1'b1;
        if (sent == CALM_AT) calm <= 1'b1;
        r     = '0;
        r.b   = draft[i];
        r.eot = (i == draft.size() - 1);
        offer_row(r);
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (marked_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
